// ===== design/single_wire_sensor_reader_assert.svh =====
// Assertion macros shared by the checker of the single-wire sensor reader.
`ifndef SINGLE_WIRE_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_READER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWSR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swsr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SWSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swsr assertion failed");

`endif

// ===== design/swsr_pkg.sv =====
`default_nettype none

package swsr_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int COUNT_WIDTH   = 16;
   localparam int ADDR_WIDTH    = 5;
   localparam int DATA_WIDTH    = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   localparam logic [2:0] REG_START_LOW   = 3'd0;
   localparam logic [2:0] REG_START_HIGH  = 3'd1;
   localparam logic [2:0] REG_RESP_LIMIT  = 3'd2;
   localparam logic [2:0] REG_BIT_LIMIT   = 3'd3;
   localparam logic [2:0] REG_ONE_THRESH  = 3'd4;
   localparam logic [2:0] REG_FRAME_BYTES = 3'd5;

   typedef enum logic [1:0] {
      STATUS_IDLE        = 2'd0,
      STATUS_BUSY        = 2'd1,
      STATUS_NO_RESPONSE = 2'd2,
      STATUS_BIT_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PHASE_IDLE       = 3'd0,
      PHASE_START_LOW  = 3'd1,
      PHASE_START_HIGH = 3'd2,
      PHASE_RESP_LOW   = 3'd3,
      PHASE_RESP_HIGH  = 3'd4,
      PHASE_BIT_LOW    = 3'd5,
      PHASE_BIT_HIGH   = 3'd6
   } phase_type;

endpackage

`default_nettype wire

// ===== design/single_wire_sensor_reader.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_func, req_pin_level
// rsp       out        rsp_valid / rsp_ready  rsp_drive_low, rsp_drive_enable, rsp_byte_valid,
//                                             rsp_data_byte, rsp_last_byte, rsp_status
// csr       in/out     psel, penable / pready paddr, pwrite, pwdata, prdata
//
// An item is taken in each cycle that req_ready is high, and its result is registered.
// The single output register sets the rate: a new item is taken whenever it is empty or
// its result is being taken in the same cycle.
// A stall on the result side holds the result and stops input until it is taken.
// Reset is synchronous, empties the output register and resets the CSR and state registers.
`default_nettype none

module single_wire_sensor_reader
   import swsr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  req_func,
   input  wire logic                  req_pin_level,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_drive_low,
   output      logic                  rsp_drive_enable,
   output      logic                  rsp_byte_valid,
   output      logic [7:0]            rsp_data_byte,
   output      logic                  rsp_last_byte,
   output      logic [1:0]            rsp_status,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_WIDTH-1:0] paddr,
   input  wire logic [DATA_WIDTH-1:0] pwdata,
   output      logic [DATA_WIDTH-1:0] prdata,
   output      logic                  pready
);

   logic [15:0] start_low_ff;
   logic [7:0]  start_high_ff;
   logic [7:0]  resp_limit_ff;
   logic [7:0]  bit_limit_ff;
   logic [7:0]  one_thresh_ff;
   logic [3:0]  frame_bytes_ff;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [2:0]             bit_index_ff, bit_index_in;
   logic [7:0]             shift_ff, shift_in;
   logic [2:0]             byte_index_ff, byte_index_in;
   status_type             error_ff, error_in;

   logic       rsp_valid_ff;
   logic       drive_low_ff, drive_low_in;
   logic       drive_enable_ff, drive_enable_in;
   logic       byte_valid_ff, byte_valid_in;
   logic [7:0] data_byte_ff, data_byte_in;
   logic       last_byte_ff, last_byte_in;
   status_type status_ff, status_in;

   logic                   accept;
   logic                   csr_write;
   logic [COUNT_WIDTH-1:0] count_up;
   logic [3:0]             frame_bytes;
   logic                   bit_value;
   logic [7:0]             shifted;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_ff   <= 16'd25000;
         start_high_ff  <= 8'd25;
         resp_limit_ff  <= 8'd100;
         bit_limit_ff   <= 8'd100;
         one_thresh_ff  <= 8'd50;
         frame_bytes_ff <= 4'd5;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            REG_START_LOW:   start_low_ff   <= pwdata[15:0];
            REG_START_HIGH:  start_high_ff  <= pwdata[7:0];
            REG_RESP_LIMIT:  resp_limit_ff  <= pwdata[7:0];
            REG_BIT_LIMIT:   bit_limit_ff   <= pwdata[7:0];
            REG_ONE_THRESH:  one_thresh_ff  <= pwdata[7:0];
            REG_FRAME_BYTES: frame_bytes_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_START_LOW:   prdata = DATA_WIDTH'(start_low_ff);
         REG_START_HIGH:  prdata = DATA_WIDTH'(start_high_ff);
         REG_RESP_LIMIT:  prdata = DATA_WIDTH'(resp_limit_ff);
         REG_BIT_LIMIT:   prdata = DATA_WIDTH'(bit_limit_ff);
         REG_ONE_THRESH:  prdata = DATA_WIDTH'(one_thresh_ff);
         REG_FRAME_BYTES: prdata = DATA_WIDTH'(frame_bytes_ff);
         default:         prdata = '0;
      endcase
   end

   assign count_up    = (tick_ff == COUNT_MAX) ? tick_ff : tick_ff + 1'b1;
   assign frame_bytes = (frame_bytes_ff == 4'd0) ? 4'd1 :
                        (frame_bytes_ff > 4'd8)  ? 4'd8 : frame_bytes_ff;
   assign bit_value   = tick_ff > COUNT_WIDTH'(one_thresh_ff);
   assign shifted     = {shift_ff[6:0], bit_value};

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      byte_index_in = byte_index_ff;
      error_in      = error_ff;
      byte_valid_in = 1'b0;
      data_byte_in  = 8'd0;
      last_byte_in  = 1'b0;

      if (req_func == FUNC_START) begin
         phase_in      = PHASE_START_LOW;
         tick_in       = '0;
         bit_index_in  = '0;
         shift_in      = '0;
         byte_index_in = '0;
         error_in      = STATUS_IDLE;
      end else begin
         unique case (phase_ff)
            PHASE_IDLE: ;
            PHASE_START_LOW: begin
               tick_in = count_up;
               if (count_up >= COUNT_WIDTH'(start_low_ff) || count_up == COUNT_MAX) begin
                  phase_in = PHASE_START_HIGH;
                  tick_in  = '0;
               end
            end
            PHASE_START_HIGH: begin
               tick_in = count_up;
               if (count_up >= COUNT_WIDTH'(start_high_ff) || count_up == COUNT_MAX) begin
                  phase_in = PHASE_RESP_LOW;
                  tick_in  = '0;
               end
            end
            PHASE_RESP_LOW: begin
               if (req_pin_level) begin
                  phase_in = PHASE_RESP_HIGH;
                  tick_in  = '0;
               end else if (count_up >= COUNT_WIDTH'(resp_limit_ff)) begin
                  phase_in = PHASE_IDLE;
                  tick_in  = '0;
                  error_in = STATUS_NO_RESPONSE;
               end else begin
                  tick_in = count_up;
               end
            end
            PHASE_RESP_HIGH: begin
               if (!req_pin_level) begin
                  phase_in      = PHASE_BIT_LOW;
                  tick_in       = '0;
                  bit_index_in  = '0;
                  shift_in      = '0;
                  byte_index_in = '0;
               end else if (count_up >= COUNT_WIDTH'(resp_limit_ff)) begin
                  phase_in = PHASE_IDLE;
                  tick_in  = '0;
                  error_in = STATUS_NO_RESPONSE;
               end else begin
                  tick_in = count_up;
               end
            end
            PHASE_BIT_LOW: begin
               if (req_pin_level) begin
                  phase_in = PHASE_BIT_HIGH;
                  tick_in  = '0;
               end else if (count_up > COUNT_WIDTH'(bit_limit_ff)) begin
                  phase_in = PHASE_IDLE;
                  tick_in  = '0;
                  error_in = STATUS_BIT_TIMEOUT;
               end else begin
                  tick_in = count_up;
               end
            end
            PHASE_BIT_HIGH: begin
               if (!req_pin_level) begin
                  tick_in  = '0;
                  phase_in = PHASE_BIT_LOW;
                  shift_in = shifted;
                  if (bit_index_ff == 3'(BITS_PER_BYTE - 1)) begin
                     byte_valid_in = 1'b1;
                     data_byte_in  = shifted;
                     bit_index_in  = '0;
                     shift_in      = '0;
                     if (({1'b0, byte_index_ff} + 4'd1) >= frame_bytes) begin
                        last_byte_in  = 1'b1;
                        byte_index_in = '0;
                        phase_in      = PHASE_IDLE;
                     end else begin
                        byte_index_in = byte_index_ff + 3'd1;
                     end
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                  end
               end else if (count_up > COUNT_WIDTH'(bit_limit_ff)) begin
                  phase_in = PHASE_IDLE;
                  tick_in  = '0;
                  error_in = STATUS_BIT_TIMEOUT;
               end else begin
                  tick_in = count_up;
               end
            end
            default: phase_in = PHASE_IDLE;
         endcase
      end

      drive_low_in    = (phase_in == PHASE_START_LOW);
      drive_enable_in = (phase_in == PHASE_START_LOW) || (phase_in == PHASE_START_HIGH);
      status_in       = (phase_in != PHASE_IDLE) ? STATUS_BUSY : error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         tick_ff       <= '0;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         byte_index_ff <= '0;
         error_ff      <= STATUS_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            tick_ff       <= tick_in;
            bit_index_ff  <= bit_index_in;
            shift_ff      <= shift_in;
            byte_index_ff <= byte_index_in;
            error_ff      <= error_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         drive_low_ff    <= drive_low_in;
         drive_enable_ff <= drive_enable_in;
         byte_valid_ff   <= byte_valid_in;
         data_byte_ff    <= data_byte_in;
         last_byte_ff    <= last_byte_in;
         status_ff       <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_low    = drive_low_ff;
   assign rsp_drive_enable = drive_enable_ff;
   assign rsp_byte_valid   = byte_valid_ff;
   assign rsp_data_byte    = data_byte_ff;
   assign rsp_last_byte    = last_byte_ff;
   assign rsp_status       = status_ff;

endmodule

`default_nettype wire

// ===== design/swsr_checker.sv =====
`default_nettype none

`include "single_wire_sensor_reader_assert.svh"

module swsr_checker
   import swsr_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_drive_low,
   input wire logic       rsp_drive_enable,
   input wire logic       rsp_byte_valid,
   input wire logic [7:0] rsp_data_byte,
   input wire logic       rsp_last_byte,
   input wire logic [1:0] rsp_status
);

   // A result that is held back must stay unchanged until it is taken.
   `SWSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_byte) && $stable(rsp_status))

   // The input side may only stall while an untaken result is waiting.
   `SWSR_ASSERT_SAME(a_ready_free, clock, reset, !rsp_valid, req_ready)

   // Pulling the line low is only possible while the host drives it.
   `SWSR_ASSERT_SAME(a_drive_low, clock, reset, rsp_valid && rsp_drive_low, rsp_drive_enable && rsp_status == STATUS_BUSY)

   // An item without a byte carries neither data nor the last-byte mark.
   `SWSR_ASSERT_SAME(a_no_byte, clock, reset, rsp_valid && !rsp_byte_valid, rsp_data_byte == 8'd0 && !rsp_last_byte)

   // The final byte of a frame ends the reading with a clean idle status.
   `SWSR_ASSERT_SAME(a_last_idle, clock, reset, rsp_valid && rsp_last_byte, rsp_byte_valid && rsp_status == STATUS_IDLE && !rsp_drive_enable)

endmodule

bind single_wire_sensor_reader swsr_checker u_swsr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_drive_low    (rsp_drive_low),
   .rsp_drive_enable (rsp_drive_enable),
   .rsp_byte_valid   (rsp_byte_valid),
   .rsp_data_byte    (rsp_data_byte),
   .rsp_last_byte    (rsp_last_byte),
   .rsp_status       (rsp_status)
);

`default_nettype wire
